// ===== src/tcp_connection_receive_fsm_assert.svh =====
// Assertion macros for the TCP connection receive block.
`ifndef TCP_CONNECTION_RECEIVE_FSM_ASSERT_SVH
`define TCP_CONNECTION_RECEIVE_FSM_ASSERT_SVH
`ifndef ASSERT_OFF
`define TCRF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TCRF_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TCRF_ASSERT(label, clk, rst_n, prop, msg)
`define TCRF_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ===== src/tcrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP receive state machine package
// Codes for states, flags, operations, replies and events shared by the block.
// ----------------------------------------------------------------------------
package tcrf_pkg;
    localparam logic [3:0] ST_CLOSED     = 4'd0;
    localparam logic [3:0] ST_LISTEN     = 4'd1;
    localparam logic [3:0] ST_SYN_RCVD   = 4'd3;
    localparam logic [3:0] ST_ESTAB      = 4'd4;
    localparam logic [3:0] ST_FIN_WAIT1  = 4'd5;
    localparam logic [3:0] ST_FIN_WAIT2  = 4'd6;
    localparam logic [3:0] ST_CLOSE_WAIT = 4'd7;
    localparam logic [3:0] ST_CLOSING    = 4'd8;
    localparam logic [3:0] ST_LAST_ACK   = 4'd9;
    localparam logic [3:0] ST_TIME_WAIT  = 4'd10;

    localparam int FL_FIN = 0;
    localparam int FL_SYN = 1;
    localparam int FL_RST = 2;
    localparam int FL_ACK = 4;

    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_LOCAL = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    localparam logic [1:0] RK_NONE   = 2'd0;
    localparam logic [1:0] RK_ACK    = 2'd1;
    localparam logic [1:0] RK_RST    = 2'd2;
    localparam logic [1:0] RK_SYNACK = 2'd3;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_ABORT     = 3'd1;
    localparam logic [2:0] EV_CLOSE     = 3'd2;
    localparam logic [2:0] EV_WINDOW    = 3'd3;
    localparam logic [2:0] EV_DESTROYED = 3'd4;

    typedef struct packed {
        logic [3:0]  fsm_state;
        logic [31:0] snd_una;
        logic [31:0] snd_nxt;
        logic [15:0] snd_wnd;
        logic [31:0] snd_wl1;
        logic [31:0] snd_wl2;
        logic [31:0] rcv_nxt;
        logic [15:0] rcv_wnd;
    } tcb_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [5:0]  seg_flags;
        logic [15:0] seg_window;
        logic [15:0] payload_bytes;
        logic [31:0] initial_seq;
    } seg_t;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [31:0] reply_seq;
        logic [31:0] reply_ackno;
        logic        reply_ack_flag;
        logic        deliver;
        logic [15:0] front_trim;
        logic [15:0] deliver_bytes;
        logic [2:0]  event_res;
        logic [31:0] acked_upto;
        logic        all_acked;
        logic        start_time_wait;
        logic [3:0]  conn_state;
    } res_t;

    function automatic logic seq_between(input logic [31:0] x, input logic [31:0] lo,
                                         input logic [31:0] hi);
        seq_between = (hi - lo) >= (x - lo);
    endfunction

    function automatic logic seq_gt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        seq_gt = (d != 32'd0) && !d[31];
    endfunction

    // Half a sequence space apart counts as less than.
    function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        seq_lt = d[31];
    endfunction
endpackage
`default_nettype wire

// ===== src/tcrf_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// TCP receive step logic
// Combinational next control block and result for one item.
// ----------------------------------------------------------------------------
module tcrf_step (
    input  wire tcrf_pkg::tcb_t tcb,
    input  wire tcrf_pkg::seg_t seg,
    input  wire                 notify_en,
    output tcrf_pkg::tcb_t      tcb_next,
    output tcrf_pkg::res_t      res
);
    always_comb begin
        logic [16:0] tcplen;
        logic [31:0] trim;
        logic [31:0] len32;
        logic [31:0] base;
        logic [31:0] outstanding;
        logic [31:0] data_left;
        logic        ok;
        logic        fin;
        logic        done;
        logic        syn_fin;
        logic [5:0]  fl;
        tcrf_pkg::tcb_t n;
        tcrf_pkg::res_t r;

        n = tcb;
        r = '0;
        fl = seg.seg_flags;
        syn_fin = fl[tcrf_pkg::FL_FIN] | fl[tcrf_pkg::FL_SYN];
        tcplen = {1'b0, seg.payload_bytes} + {16'd0, syn_fin};
        trim = tcb.rcv_nxt - seg.seg_seq;
        len32 = {15'd0, tcplen} - trim;
        base = tcb.rcv_nxt;
        outstanding = tcb.snd_nxt - tcb.snd_una;
        data_left = ({16'd0, seg.payload_bytes} > trim) ?
                    {16'd0, seg.payload_bytes} - trim : 32'd0;
        fin = fl[tcrf_pkg::FL_FIN];
        done = 1'b0;
        ok = 1'b0;

        unique case (seg.operation)
            tcrf_pkg::OP_RX: begin
                if (tcb.fsm_state == tcrf_pkg::ST_LISTEN) begin
                    if (fl[tcrf_pkg::FL_RST]) begin
                    end else if (fl[tcrf_pkg::FL_ACK]) begin
                        r.reply_kind = tcrf_pkg::RK_RST;
                        r.reply_seq = seg.seg_ack;
                    end else if (fl == 6'b000010) begin
                        n.fsm_state = tcrf_pkg::ST_SYN_RCVD;
                        n.rcv_nxt = seg.seg_seq + 32'd1;
                        n.snd_una = seg.initial_seq;
                        n.snd_nxt = seg.initial_seq + 32'd1;
                        n.snd_wnd = seg.seg_window;
                        n.rcv_wnd = seg.seg_window;
                        n.snd_wl1 = '0;
                        n.snd_wl2 = '0;
                        r.reply_kind = tcrf_pkg::RK_SYNACK;
                    end
                end else if (tcb.fsm_state >= tcrf_pkg::ST_SYN_RCVD &&
                             tcb.fsm_state <= tcrf_pkg::ST_TIME_WAIT) begin
                    if (tcplen == 17'd0) ok = (seg.seg_seq == tcb.rcv_nxt);
                    else ok = (tcb.rcv_wnd != 16'd0) && tcrf_pkg::seq_between(
                        tcb.rcv_nxt, seg.seg_seq,
                        seg.seg_seq + {15'd0, tcplen} - 32'd1);
                    if (!ok) begin
                        if (!fl[tcrf_pkg::FL_RST]) r.reply_kind = tcrf_pkg::RK_ACK;
                        done = 1'b1;
                    end else begin
                        r.front_trim = trim[15:0];
                    end
                    if (!done && fl[tcrf_pkg::FL_RST]) begin
                        done = 1'b1;
                        if (tcb.fsm_state == tcrf_pkg::ST_SYN_RCVD) begin
                            n.fsm_state = tcrf_pkg::ST_LISTEN;
                            r.event_res = tcrf_pkg::EV_ABORT;
                        end else begin
                            r.event_res = (tcb.fsm_state >= tcrf_pkg::ST_ESTAB &&
                                           tcb.fsm_state <= tcrf_pkg::ST_CLOSE_WAIT) ?
                                          tcrf_pkg::EV_ABORT : tcrf_pkg::EV_DESTROYED;
                            n.fsm_state = tcrf_pkg::ST_CLOSED;
                        end
                    end
                    if (!done && fl[tcrf_pkg::FL_SYN]) begin
                        done = 1'b1;
                        r.reply_kind = tcrf_pkg::RK_RST;
                        r.reply_seq = seg.seg_ack;
                        r.reply_ackno = base + len32;
                        r.reply_ack_flag = 1'b1;
                        n.fsm_state = tcrf_pkg::ST_CLOSED;
                        r.event_res = tcrf_pkg::EV_ABORT;
                    end
                    if (!done && !fl[tcrf_pkg::FL_ACK]) done = 1'b1;
                    // The handshake completes before the ordinary ACK processing.
                    if (!done && tcb.fsm_state == tcrf_pkg::ST_SYN_RCVD) begin
                        if (!tcrf_pkg::seq_between(seg.seg_ack, tcb.snd_una + 32'd1,
                                                   tcb.snd_nxt)) begin
                            r.reply_kind = tcrf_pkg::RK_RST;
                            r.reply_seq = seg.seg_ack;
                            done = 1'b1;
                        end else begin
                            n.fsm_state = tcrf_pkg::ST_ESTAB;
                            n.snd_wnd = seg.seg_window;
                            n.snd_wl1 = seg.seg_seq;
                            n.snd_wl2 = seg.seg_ack;
                        end
                    end
                    if (!done) begin
                        if (n.fsm_state >= tcrf_pkg::ST_SYN_RCVD &&
                            n.fsm_state <= tcrf_pkg::ST_CLOSING) begin
                            if (tcrf_pkg::seq_between(seg.seg_ack, n.snd_una + 32'd1,
                                                      n.snd_nxt)) begin
                                n.snd_una = seg.seg_ack;
                                if (tcrf_pkg::seq_lt(n.snd_wl1, seg.seg_seq) ||
                                    (n.snd_wl1 == seg.seg_seq &&
                                     !tcrf_pkg::seq_gt(n.snd_wl2, seg.seg_ack))) begin
                                    n.snd_wnd = seg.seg_window;
                                    n.snd_wl1 = seg.seg_seq;
                                    n.snd_wl2 = seg.seg_ack;
                                end
                                if (notify_en) r.event_res = tcrf_pkg::EV_WINDOW;
                            end else if (tcrf_pkg::seq_gt(seg.seg_ack, n.snd_nxt)) begin
                                r.reply_kind = tcrf_pkg::RK_ACK;
                                done = 1'b1;
                            end
                            if (!done) begin
                                if (n.fsm_state == tcrf_pkg::ST_FIN_WAIT1 &&
                                    seg.seg_ack == n.snd_nxt) begin
                                    n.fsm_state = tcrf_pkg::ST_FIN_WAIT2;
                                end else if (n.fsm_state == tcrf_pkg::ST_CLOSING &&
                                             seg.seg_ack == n.snd_nxt) begin
                                    n.fsm_state = tcrf_pkg::ST_TIME_WAIT;
                                    r.start_time_wait = 1'b1;
                                end
                            end
                        end else if (n.fsm_state == tcrf_pkg::ST_LAST_ACK &&
                                     seg.seg_ack == n.snd_nxt) begin
                            n.fsm_state = tcrf_pkg::ST_CLOSED;
                            r.event_res = tcrf_pkg::EV_DESTROYED;
                            done = 1'b1;
                        end
                    end
                    if (!done && data_left != 32'd0) begin
                        if (n.fsm_state == tcrf_pkg::ST_ESTAB) begin
                            if (len32 > {16'd0, tcb.rcv_wnd}) begin
                                fin = 1'b0;
                                len32 = {16'd0, tcb.rcv_wnd};
                            end
                            n.rcv_nxt = base + len32;
                            r.deliver = 1'b1;
                            r.deliver_bytes = len32[15:0];
                        end else if (n.fsm_state == tcrf_pkg::ST_FIN_WAIT1 ||
                                     n.fsm_state == tcrf_pkg::ST_FIN_WAIT2) begin
                            r.reply_kind = tcrf_pkg::RK_RST;
                            r.reply_seq = seg.seg_ack;
                            r.reply_ackno = base + len32;
                            r.reply_ack_flag = 1'b1;
                            n.fsm_state = tcrf_pkg::ST_CLOSED;
                            r.event_res = tcrf_pkg::EV_DESTROYED;
                            done = 1'b1;
                        end
                    end
                    if (!done && fin) begin
                        n.rcv_nxt = base + len32;
                        if (n.fsm_state == tcrf_pkg::ST_ESTAB ||
                            n.fsm_state == tcrf_pkg::ST_SYN_RCVD) begin
                            n.fsm_state = tcrf_pkg::ST_CLOSE_WAIT;
                            r.event_res = tcrf_pkg::EV_CLOSE;
                        end else if (n.fsm_state == tcrf_pkg::ST_FIN_WAIT1) begin
                            n.fsm_state = tcrf_pkg::ST_CLOSING;
                        end else if (n.fsm_state == tcrf_pkg::ST_FIN_WAIT2) begin
                            n.fsm_state = tcrf_pkg::ST_TIME_WAIT;
                            r.start_time_wait = 1'b1;
                        end else if (n.fsm_state == tcrf_pkg::ST_TIME_WAIT) begin
                            r.start_time_wait = 1'b1;
                        end
                    end
                end else if (!fl[tcrf_pkg::FL_RST]) begin
                    r.reply_kind = tcrf_pkg::RK_RST;
                    if (fl[tcrf_pkg::FL_ACK]) begin
                        r.reply_seq = seg.seg_ack;
                    end else begin
                        r.reply_ackno = seg.seg_seq + {15'd0, tcplen};
                        r.reply_ack_flag = 1'b1;
                    end
                end
            end
            tcrf_pkg::OP_LOCAL: begin
                if (tcb.fsm_state == tcrf_pkg::ST_SYN_RCVD ||
                    tcb.fsm_state == tcrf_pkg::ST_ESTAB ||
                    tcb.fsm_state == tcrf_pkg::ST_CLOSE_WAIT) begin
                    if ({16'd0, tcb.snd_wnd} > outstanding &&
                        {16'd0, seg.payload_bytes} <= {16'd0, tcb.snd_wnd} - outstanding)
                        n.snd_nxt = tcb.snd_nxt + {16'd0, seg.payload_bytes};
                    else if (seg.payload_bytes == 16'd0)
                        n.snd_nxt = tcb.snd_nxt;
                end
            end
            tcrf_pkg::OP_CLOSE: begin
                if (tcb.fsm_state == tcrf_pkg::ST_CLOSE_WAIT) begin
                    n.snd_nxt = tcb.snd_nxt + 32'd1;
                    n.fsm_state = tcrf_pkg::ST_LAST_ACK;
                end else if (tcb.fsm_state == tcrf_pkg::ST_SYN_RCVD ||
                             tcb.fsm_state == tcrf_pkg::ST_ESTAB) begin
                    n.snd_nxt = tcb.snd_nxt + 32'd1;
                    n.fsm_state = tcrf_pkg::ST_FIN_WAIT1;
                end
            end
            default: begin
            end
        endcase

        r.acked_upto = n.snd_una;
        r.all_acked = (n.fsm_state == tcrf_pkg::ST_CLOSED) ||
                      (n.fsm_state == tcrf_pkg::ST_LISTEN) || (n.snd_una == n.snd_nxt);
        r.conn_state = n.fsm_state;
        tcb_next = n;
        res = r;
    end
endmodule
`default_nettype wire

// ===== src/tcp_connection_receive_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result: an accepted item's result is registered in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while the result is taken; the control block update is a single pass of logic.
// The output register frees the input while a result waits, if it is taken that cycle.
// Reset: synchronous, active low; state LISTEN, all sequence variables zero.
// ----------------------------------------------------------------------------
// TCP connection receive state machine
// One connection control block with valid/ready segment and result channels.
// ----------------------------------------------------------------------------
`include "tcp_connection_receive_fsm_assert.svh"
module tcp_connection_receive_fsm (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_operation,
    input  wire  [31:0] s_seg_seq,
    input  wire  [31:0] s_seg_ack,
    input  wire  [5:0]  s_seg_flags,
    input  wire  [15:0] s_seg_window,
    input  wire  [15:0] s_payload_bytes,
    input  wire  [31:0] s_initial_seq,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_reply_kind,
    output logic [31:0] m_reply_seq,
    output logic [31:0] m_reply_ackno,
    output logic        m_reply_ack_flag,
    output logic        m_deliver,
    output logic [15:0] m_front_trim,
    output logic [15:0] m_deliver_bytes,
    output logic [2:0]  m_event_res,
    output logic [31:0] m_acked_upto,
    output logic        m_all_acked,
    output logic        m_start_time_wait,
    output logic [3:0]  m_conn_state
);
    tcrf_pkg::tcb_t tcb_reg, tcb_next;
    tcrf_pkg::seg_t seg;
    tcrf_pkg::res_t res_reg, res_next;
    logic           notify_reg;
    logic           m_valid_reg;
    logic           accept;

    assign seg = '{operation: s_operation, seg_seq: s_seg_seq, seg_ack: s_seg_ack,
                   seg_flags: s_seg_flags, seg_window: s_seg_window,
                   payload_bytes: s_payload_bytes, initial_seq: s_initial_seq};

    tcrf_step u_step (
        .tcb      (tcb_reg),
        .seg      (seg),
        .notify_en(notify_reg),
        .tcb_next (tcb_next),
        .res      (res_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tcb_reg <= '0;
            tcb_reg.fsm_state <= tcrf_pkg::ST_LISTEN;
            notify_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) notify_reg <= cfg_data;
            if (accept) begin
                tcb_reg <= tcb_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) res_reg <= res_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_reply_kind      = res_reg.reply_kind;
    assign m_reply_seq       = res_reg.reply_seq;
    assign m_reply_ackno     = res_reg.reply_ackno;
    assign m_reply_ack_flag  = res_reg.reply_ack_flag;
    assign m_deliver         = res_reg.deliver;
    assign m_front_trim      = res_reg.front_trim;
    assign m_deliver_bytes   = res_reg.deliver_bytes;
    assign m_event_res       = res_reg.event_res;
    assign m_acked_upto      = res_reg.acked_upto;
    assign m_all_acked       = res_reg.all_acked;
    assign m_start_time_wait = res_reg.start_time_wait;
    assign m_conn_state      = res_reg.conn_state;

    `TCRF_ASSERT(a_stall_holds, aclk, aresetn, m_valid_reg && !m_ready |=> m_valid_reg && $stable(tcb_reg), "state moved while result stalled")
    `TCRF_ASSERT(a_state_tracks, aclk, aresetn, m_valid_reg |-> res_reg.conn_state == tcb_reg.fsm_state, "reported state differs from held state")
    `TCRF_ASSERT(a_acked_tracks, aclk, aresetn, m_valid_reg |-> res_reg.acked_upto == tcb_reg.snd_una, "acked point differs from held state")
    `TCRF_ASSERT_RST(a_reset_state, aclk, !aresetn |=> !m_valid_reg && tcb_reg.fsm_state == tcrf_pkg::ST_LISTEN, "reset did not restore LISTEN")
endmodule
`default_nettype wire
